>>> design/vpss_pkg.sv
package vpss_pkg;

    // Configuration register indexes
    localparam int unsigned CfgIdxW = 2;
    typedef enum logic [CfgIdxW-1:0] {
        CFG_PACKET_LENGTH = 2'd0,
        CFG_PACKET_LIMIT  = 2'd1
    } t_cfg_idx;

    localparam int unsigned CfgDataW = 10;

    localparam logic [8:0] PKT_LEN_MIN   = 9'd4;
    localparam logic [8:0] PKT_LEN_MAX   = 9'd256;
    localparam logic [8:0] PKT_LEN_RESET = 9'd164;
    localparam logic [9:0] PKT_LIM_RESET = 10'd300;
    localparam logic [9:0] PKT_CNT_MAX   = 10'd1023;

    localparam logic [3:0] DISCARD_NIBBLE = 4'hF;
    localparam logic [2:0] SYNC_SEGMENT   = 3'd1;
    localparam logic [7:0] SYNC_MAX_PKT   = 8'd60;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_word;

    typedef struct packed {
        logic       is_discard;
        logic [2:0] segment;
        logic [7:0] packet_number;
        logic [9:0] packets_seen;
        logic       synced;
        logic       gave_up;
    } t_out_word;

    // Last byte position of a packet for a programmed length, clamped to 4..256.
    function automatic logic [7:0] last_pos(input logic [8:0] len);
        logic [8:0] eff;
        begin
            if (len < PKT_LEN_MIN) begin
                eff = PKT_LEN_MIN;
            end else if (len > PKT_LEN_MAX) begin
                eff = PKT_LEN_MAX;
            end else begin
                eff = len;
            end
            last_pos = 8'(eff - 9'd1);
        end
    endfunction

endpackage

>>> design/video_packet_sync_search.sv
// Channel   Direction  Handshake                 Payload
// --------  ---------  ------------------------  ----------------------------------
// in        sink       i_in_valid / o_in_stall   i_in_word  (data_byte, restart)
// out       source     o_out_valid / i_out_stall o_out_word (header fields, status)
// cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One byte word is taken every cycle unless o_in_stall holds it; its result (on a packet's
// last byte) appears in the output register in the next cycle, set by the single header/count stage.
// o_in_stall is raised only while a result sits in the output register and the
// output side stalls, so one output register decouples the two sides.
// Reset is synchronous, active low; clears position, count, search state and output valid, loads config defaults.
// Config writes are always ready and are applied at the write edge.

module video_packet_sync_search
    import vpss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_word            i_in_word,

    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_word           o_out_word,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    // Config: packet length is kept as its clamped last byte position.
    logic [7:0] r_last_pos;
    logic [9:0] r_pkt_limit;

    // Search state
    logic [7:0] r_pos, n_pos;
    logic [7:0] r_hdr_hi, n_hdr_hi;
    logic [7:0] r_hdr_lo, n_hdr_lo;
    logic [9:0] r_pkt_cnt, n_pkt_cnt;
    logic       r_done, n_done;

    // Output register
    logic       r_out_valid, n_out_valid;
    t_out_word  r_out_word, n_out_word;

    logic       in_accept;
    logic       cfg_write;

    // Restart-adjusted view of the state for this word
    logic [7:0] cur_pos;
    logic [9:0] cur_cnt;
    logic       cur_done;

    logic       discard;
    logic [2:0] segment;
    logic [9:0] cnt_inc;
    logic       synced;
    logic       gave_up;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid & o_cfg_ready;

    // Hold input only when the result register is full and not draining.
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pos  <= last_pos(PKT_LEN_RESET);
            r_pkt_limit <= PKT_LIM_RESET;
        end else if (cfg_write) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PACKET_LENGTH: r_last_pos  <= last_pos(i_cfg_data[8:0]);
                CFG_PACKET_LIMIT:  r_pkt_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Header fields come from the stored bytes: the last position is at least 3,
    // so both header bytes are already in place when a packet ends.
    assign discard = (r_hdr_hi[3:0] == DISCARD_NIBBLE);
    assign segment = r_hdr_hi[6:4];
    assign cnt_inc = (cur_cnt == PKT_CNT_MAX) ? PKT_CNT_MAX : cur_cnt + 10'd1;
    assign synced  = ~discard & (segment == SYNC_SEGMENT) & (r_hdr_lo < SYNC_MAX_PKT);
    // A zero limit behaves as one since the count is at least one here.
    assign gave_up = ~synced & (cnt_inc >= r_pkt_limit);

    always_comb begin
        cur_pos   = i_in_word.restart ? 8'd0  : r_pos;
        cur_cnt   = i_in_word.restart ? 10'd0 : r_pkt_cnt;
        cur_done  = i_in_word.restart ? 1'b0  : r_done;

        n_pos       = r_pos;
        n_hdr_hi    = r_hdr_hi;
        n_hdr_lo    = r_hdr_lo;
        n_pkt_cnt   = r_pkt_cnt;
        n_done      = r_done;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_word  = r_out_word;

        if (in_accept) begin
            n_pos     = cur_pos;
            n_pkt_cnt = cur_cnt;
            n_done    = cur_done;
            if (!cur_done) begin
                if (cur_pos == 8'd0) begin
                    n_hdr_hi = i_in_word.data_byte;
                end else if (cur_pos == 8'd1) begin
                    n_hdr_lo = i_in_word.data_byte;
                end

                if (cur_pos < r_last_pos) begin
                    n_pos = cur_pos + 8'd1;
                end else begin
                    // Packet ends (also when the length was cut below the position).
                    n_pos       = 8'd0;
                    n_pkt_cnt   = cnt_inc;
                    n_done      = synced | gave_up;
                    n_out_valid = 1'b1;
                    n_out_word.is_discard    = discard;
                    n_out_word.segment       = segment;
                    n_out_word.packet_number = r_hdr_lo;
                    n_out_word.packets_seen  = cnt_inc;
                    n_out_word.synced        = synced;
                    n_out_word.gave_up       = gave_up;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 8'd0;
            r_hdr_hi    <= 8'd0;
            r_hdr_lo    <= 8'd0;
            r_pkt_cnt   <= 10'd0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_hdr_hi    <= n_hdr_hi;
            r_hdr_lo    <= n_hdr_lo;
            r_pkt_cnt   <= n_pkt_cnt;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

endmodule

>>> design/vpss_checker.sv
module vpss_props
    import vpss_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input t_out_word           o_out_word
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    // A full, stalled output register back-pressures the input.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input not stalled while output is blocked");

    // Success and give-up never come together.
    a_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.synced && o_out_word.gave_up))
        else $error("synced and gave_up both set");

    // Every reported packet counts at least itself.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.packets_seen != 10'd0)
        else $error("packets_seen is zero on a result");

endmodule

bind video_packet_sync_search vpss_props u_vpss_props (.*);
